// ===== hw/rtl/gbts_pkg.sv =====
package gbts_pkg;

	// Default store size in bytes; one byte of the store is always kept free.
	localparam int CAPACITY_DEF = 64;

	// Fixed field widths of the request and result items.
	localparam int LW = 6;
	localparam int CW = 8;
	// Internal index width: holds any store index and the end of the gap.
	localparam int IW = 7;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_ERASE  = 2'd1;
	localparam logic [1:0] MODE_READ   = 2'd2;

	localparam logic [1:0] STATUS_OK   = 2'd0;
	localparam logic [1:0] STATUS_FULL = 2'd1;
	localparam logic [1:0] STATUS_BAD  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MOVE,
		ST_APPLY,
		ST_EMIT,
		ST_TERM,
		ST_RESULT
	} gbts_state_t;

	typedef struct packed {
		logic [CW-1:0] char_out;
		logic [1:0]    status;
		logic [LW-1:0] text_length;
		logic          last;
	} gbts_res_t;

endpackage

// ===== hw/rtl/gbts_if.sv =====
interface gbts_in_if;
	logic                     valid;
	logic                     ready;
	logic [1:0]               mode;
	logic [gbts_pkg::LW-1:0]  position;
	logic [gbts_pkg::CW-1:0]  char_in;
	logic [gbts_pkg::LW-1:0]  erase_count;

	modport source (output valid, output mode, output position, output char_in,
		output erase_count, input ready);
	modport sink (input valid, input mode, input position, input char_in,
		input erase_count, output ready);
endinterface

interface gbts_out_if;
	logic                     valid;
	logic                     ready;
	logic [gbts_pkg::CW-1:0]  char_out;
	logic [1:0]               status;
	logic [gbts_pkg::LW-1:0]  text_length;
	logic                     last;

	modport source (output valid, output char_out, output status, output text_length,
		output last, input ready);
	modport sink (input valid, input char_out, input status, input text_length,
		input last, output ready);
endinterface

// ===== hw/rtl/gbts_store.sv =====
module gbts_store #(
	parameter int CAPACITY = gbts_pkg::CAPACITY_DEF,
	parameter int AW       = $clog2(CAPACITY)
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [AW-1:0]           waddr,
	input  logic [gbts_pkg::CW-1:0] wdata,
	input  logic                    re,
	input  logic [AW-1:0]           raddr,
	output logic [gbts_pkg::CW-1:0] rdata
);

	logic [gbts_pkg::CW-1:0] mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/gbts_seq.sv =====
module gbts_seq #(
	parameter int CAPACITY = gbts_pkg::CAPACITY_DEF,
	parameter int AW       = $clog2(CAPACITY)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	gbts_in_if.sink                 req,
	output logic                    push,
	output gbts_pkg::gbts_res_t     res,
	input  logic                    res_free,
	output logic                    mem_we,
	output logic [AW-1:0]           mem_waddr,
	output logic [gbts_pkg::CW-1:0] mem_wdata,
	output logic                    mem_re,
	output logic [AW-1:0]           mem_raddr,
	input  logic [gbts_pkg::CW-1:0] mem_rdata
);

	localparam logic [gbts_pkg::IW-1:0] CAP_I = gbts_pkg::IW'(CAPACITY);

	gbts_pkg::gbts_state_t state_q, state_d;

	logic [1:0]                mode_q;
	logic [gbts_pkg::LW-1:0]   pos_q;
	logic [gbts_pkg::CW-1:0]   char_q;
	logic [gbts_pkg::LW-1:0]   ecnt_q;
	logic [gbts_pkg::LW-1:0]   len_q;
	logic [gbts_pkg::LW-1:0]   gs_q;
	logic [gbts_pkg::LW-1:0]   dest_q;
	logic [1:0]                st_q;
	logic [gbts_pkg::IW-1:0]   src_q;
	logic [gbts_pkg::IW-1:0]   dst_q;
	logic [gbts_pkg::IW-1:0]   wdst_q;
	logic                      left_q;
	logic [gbts_pkg::LW-1:0]   mv_cnt_q;
	logic                      pend_q;
	logic [gbts_pkg::LW-1:0]   idx_q;

	logic [gbts_pkg::IW-1:0]   pos_i, len_i, gs_i, sum_i, ge_i;
	logic [gbts_pkg::LW-1:0]   dest_c;
	logic [gbts_pkg::LW-1:0]   idx_nx;
	logic                      err_c;
	logic [1:0]                err_st_c;
	logic                      left_c;
	logic                      move_done;

	assign pos_i  = {1'b0, pos_q};
	assign len_i  = {1'b0, len_q};
	assign gs_i   = {1'b0, gs_q};
	assign sum_i  = pos_i + {1'b0, ecnt_q};
	assign ge_i   = gs_i + CAP_I - len_i;
	assign idx_nx = idx_q + gbts_pkg::LW'(1);
	assign left_c = (dest_c < gs_q);
	assign move_done = (mv_cnt_q == '0) && !pend_q;

	// Request checks and the text index the gap has to reach.
	always_comb begin
		err_c    = 1'b0;
		err_st_c = gbts_pkg::STATUS_OK;
		dest_c   = len_q;
		case (mode_q)
			gbts_pkg::MODE_INSERT: begin
				dest_c = pos_q;
				if (pos_q > len_q) begin
					err_c    = 1'b1;
					err_st_c = gbts_pkg::STATUS_BAD;
				end else if (len_i + gbts_pkg::IW'(1) >= CAP_I) begin
					err_c    = 1'b1;
					err_st_c = gbts_pkg::STATUS_FULL;
				end
			end
			gbts_pkg::MODE_ERASE: begin
				dest_c = sum_i[gbts_pkg::LW-1:0];
				if (sum_i > len_i) begin
					err_c    = 1'b1;
					err_st_c = gbts_pkg::STATUS_BAD;
				end
			end
			gbts_pkg::MODE_READ: begin
				dest_c = len_q;
			end
			default: begin
				err_c    = 1'b1;
				err_st_c = gbts_pkg::STATUS_BAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbts_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		push      = 1'b0;
		res       = '{char_out: '0, status: st_q, text_length: len_q, last: 1'b1};
		mem_we    = 1'b0;
		mem_waddr = wdst_q[AW-1:0];
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = src_q[AW-1:0];
		case (state_q)
			gbts_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = gbts_pkg::ST_CHECK;
				end
			end
			gbts_pkg::ST_CHECK: begin
				state_d = err_c ? gbts_pkg::ST_RESULT : gbts_pkg::ST_MOVE;
			end
			gbts_pkg::ST_MOVE: begin
				mem_re = (mv_cnt_q != '0);
				mem_we = pend_q;
				if (move_done) begin
					state_d = gbts_pkg::ST_APPLY;
				end
			end
			gbts_pkg::ST_APPLY: begin
				case (mode_q)
					gbts_pkg::MODE_INSERT: begin
						mem_we    = 1'b1;
						mem_waddr = dest_q[AW-1:0];
						mem_wdata = char_q;
						state_d   = gbts_pkg::ST_RESULT;
					end
					gbts_pkg::MODE_READ: begin
						if (len_q == '0) begin
							state_d = gbts_pkg::ST_TERM;
						end else begin
							mem_re    = 1'b1;
							mem_raddr = '0;
							state_d   = gbts_pkg::ST_EMIT;
						end
					end
					default: begin
						state_d = gbts_pkg::ST_RESULT;
					end
				endcase
			end
			gbts_pkg::ST_EMIT: begin
				push = 1'b1;
				res  = '{char_out: mem_rdata, status: gbts_pkg::STATUS_OK,
					text_length: len_q, last: 1'b0};
				if (res_free) begin
					if (idx_nx == len_q) begin
						state_d = gbts_pkg::ST_TERM;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = idx_nx[AW-1:0];
					end
				end
			end
			gbts_pkg::ST_TERM: begin
				push = 1'b1;
				res  = '{char_out: '0, status: gbts_pkg::STATUS_OK,
					text_length: len_q, last: 1'b1};
				if (res_free) begin
					state_d = gbts_pkg::ST_IDLE;
				end
			end
			gbts_pkg::ST_RESULT: begin
				push = 1'b1;
				if (res_free) begin
					state_d = gbts_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gbts_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= '0;
			pos_q    <= '0;
			char_q   <= '0;
			ecnt_q   <= '0;
			len_q    <= '0;
			gs_q     <= '0;
			dest_q   <= '0;
			st_q     <= gbts_pkg::STATUS_OK;
			src_q    <= '0;
			dst_q    <= '0;
			wdst_q   <= '0;
			left_q   <= 1'b0;
			mv_cnt_q <= '0;
			pend_q   <= 1'b0;
			idx_q    <= '0;
		end else begin
			case (state_q)
				gbts_pkg::ST_IDLE: begin
					if (req.valid) begin
						mode_q <= req.mode;
						pos_q  <= req.position;
						char_q <= req.char_in;
						ecnt_q <= req.erase_count;
					end
				end
				gbts_pkg::ST_CHECK: begin
					st_q   <= err_st_c;
					dest_q <= dest_c;
					left_q <= left_c;
					pend_q <= 1'b0;
					// Moving left copies downward from just below the gap start
					// into the top of the gap; moving right copies upward from
					// the gap end into the gap start.
					if (left_c) begin
						mv_cnt_q <= gs_q - dest_c;
						src_q    <= gs_i - gbts_pkg::IW'(1);
						dst_q    <= ge_i - gbts_pkg::IW'(1);
					end else begin
						mv_cnt_q <= dest_c - gs_q;
						src_q    <= ge_i;
						dst_q    <= gs_i;
					end
				end
				gbts_pkg::ST_MOVE: begin
					if (mv_cnt_q != '0) begin
						src_q    <= left_q ? src_q - gbts_pkg::IW'(1) : src_q + gbts_pkg::IW'(1);
						dst_q    <= left_q ? dst_q - gbts_pkg::IW'(1) : dst_q + gbts_pkg::IW'(1);
						wdst_q   <= dst_q;
						mv_cnt_q <= mv_cnt_q - gbts_pkg::LW'(1);
						pend_q   <= 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
					if (move_done) begin
						gs_q <= dest_q;
					end
				end
				gbts_pkg::ST_APPLY: begin
					case (mode_q)
						gbts_pkg::MODE_INSERT: begin
							gs_q  <= dest_q + gbts_pkg::LW'(1);
							len_q <= len_q + gbts_pkg::LW'(1);
						end
						gbts_pkg::MODE_ERASE: begin
							gs_q  <= pos_q;
							len_q <= len_q - ecnt_q;
						end
						default: begin
							idx_q <= '0;
						end
					endcase
				end
				gbts_pkg::ST_EMIT: begin
					if (res_free) begin
						idx_q <= idx_nx;
					end
				end
				default: begin
					idx_q <= idx_q;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/gap_buffer_text_store.sv =====
// An insert or erase is checked, moves the gap to the edit point (d places, d up to
// CAPACITY - 1), is applied and then answers. A refused request answers straight after
// the check. A read out first moves the gap to the text end, then delivers length + 1
// results at one per cycle while the output side keeps taking them.
// Throughput: one request at a time; the next is taken once its last result is registered.
// Reset clears the text length, the gap position and all control state, not the byte store.
module gap_buffer_text_store #(
	parameter int CAPACITY = gbts_pkg::CAPACITY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	gbts_in_if.sink    req,
	gbts_out_if.source rsp
);

	// Address width of the byte store.
	localparam int AW = $clog2(CAPACITY);

	// Single-port-write, single-port-read byte store shared by the gap copy,
	// the insert write and the read out.
	logic                    mem_we;
	logic [AW-1:0]           mem_waddr;
	logic [gbts_pkg::CW-1:0] mem_wdata;
	logic                    mem_re;
	logic [AW-1:0]           mem_raddr;
	logic [gbts_pkg::CW-1:0] mem_rdata;

	// Result handoff from the sequencer to the output register.
	logic                    push;
	gbts_pkg::gbts_res_t     res;
	logic                    res_free;

	// Output register: a result waits here while the sequencer goes on.
	logic                    rsp_valid_q;
	gbts_pkg::gbts_res_t     rsp_data_q;

	gbts_store #(
		.CAPACITY(CAPACITY),
		.AW      (AW)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// The sequencer checks each request, walks the gap to the edit point with a source and
	// a destination address stepper, applies the edit and streams the read out.
	gbts_seq #(
		.CAPACITY(CAPACITY),
		.AW      (AW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.push     (push),
		.res      (res),
		.res_free (res_free),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	// The register can take a new result when it is empty or is being emptied now.
	assign res_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_data_q  <= '0;
		end else if (push && res_free) begin
			rsp_valid_q <= 1'b1;
			rsp_data_q  <= res;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.char_out    = rsp_data_q.char_out;
	assign rsp.status      = rsp_data_q.status;
	assign rsp.text_length = rsp_data_q.text_length;
	assign rsp.last        = rsp_data_q.last;

endmodule
